// File: sv/assert_macros.svh
// assertion macros for the top level of the distance-vector table update block
// depends on nothing; pulled in by the top level with an include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dvt_pkg.sv
// types and constants of the distance-vector table update block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dvt_pkg;

    localparam int NODE_W    = 6;
    localparam int HOP_W     = 8;
    localparam int LINK_W    = 6;
    localparam int NODE_SPAN = 1 << NODE_W;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [HOP_W-1:0] HOP_MAX = 8'hFF;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [HOP_W-1:0]  hop_t;
    typedef logic [LINK_W-1:0] link_t;

    typedef struct packed {
        node_t dest_node;
        hop_t  recv_hop;
        link_t via_link;
        logic  last_row;
    } row_t;

    typedef struct packed {
        logic  entry_updated;
        hop_t  entry_hop;
        link_t entry_link;
        logic  row_skipped;
        logic  table_changed;
        logic  end_of_table;
    } result_t;

    // one route write, also kept as the forwarding record
    typedef struct packed {
        logic  en;
        node_t node;
        hop_t  hop;
        link_t link;
    } route_wr_t;

endpackage

// File: sv/dvt_route_table.sv
// route storage: valid flags in flops, hop and link in a memory with registered read
// depends on dvt_pkg
`timescale 1ns / 1ps

module dvt_route_table #(
    parameter int NODE_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dvt_pkg::route_wr_t wr,
    input  logic              rd_en,
    input  dvt_pkg::node_t    rd_node,
    output dvt_pkg::hop_t     rd_hop,
    output dvt_pkg::link_t    rd_link,
    input  dvt_pkg::node_t    look_node,
    output logic              look_valid
);
    import dvt_pkg::*;

    localparam int TABLE_DEPTH = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    logic [HOP_W+LINK_W-1:0] mem [TABLE_DEPTH];
    logic [HOP_W+LINK_W-1:0] rd_q_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       look_addr;

    assign wr_addr   = wr.node[ADDR_W-1:0];
    assign rd_addr   = rd_node[ADDR_W-1:0];
    assign look_addr = look_node[ADDR_W-1:0];

    // read before write on the same address
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= {wr.hop, wr.link};
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_hop     = rd_q_reg[HOP_W+LINK_W-1:LINK_W];
    assign rd_link    = rd_q_reg[LINK_W-1:0];
    assign look_valid = valid_reg[look_addr];

endmodule

// File: sv/dvt_update_logic.sv
// compare and replace decision for one row, result fields and table write
// depends on dvt_pkg
`timescale 1ns / 1ps

module dvt_update_logic #(
    parameter int NODE_COUNT = 64
) (
    input  dvt_pkg::row_t      row,
    input  dvt_pkg::node_t     own_node,
    input  logic               cur_valid,
    input  dvt_pkg::hop_t      mem_hop,
    input  dvt_pkg::link_t     mem_link,
    input  dvt_pkg::route_wr_t fwd,
    input  logic               changed_so_far,
    input  logic               commit,
    output dvt_pkg::result_t   res,
    output dvt_pkg::route_wr_t wr,
    output logic               changed_next
);
    import dvt_pkg::*;

    localparam int LIMIT_W = $clog2(NODE_COUNT + 1) + NODE_W;
    localparam logic [LIMIT_W-1:0] NODE_LIMIT = LIMIT_W'(NODE_COUNT);

    logic  skip;
    logic  in_range;
    logic  take;
    logic  fwd_hit;
    hop_t  cand;
    hop_t  cur_hop;
    link_t cur_link;

    always_comb
    begin
        skip     = (row.dest_node == own_node);
        in_range = (LIMIT_W'(row.dest_node) < NODE_LIMIT);
        // saturating hop + 1
        cand     = (row.recv_hop == HOP_MAX) ? HOP_MAX : row.recv_hop + 8'd1;
        // write from the item ahead landed as this row read the memory
        fwd_hit  = fwd.en && (fwd.node == row.dest_node);
        cur_hop  = fwd_hit ? fwd.hop : mem_hop;
        cur_link = fwd_hit ? fwd.link : mem_link;
        take     = !skip && in_range && (!cur_valid || (cand < cur_hop));

        res.entry_updated = take;
        res.row_skipped   = skip;
        res.end_of_table  = row.last_row;
        res.table_changed = row.last_row && (changed_so_far || take);
        if (take)
        begin
            res.entry_hop  = cand;
            res.entry_link = row.via_link;
        end
        else if (!skip && in_range)
        begin
            res.entry_hop  = cur_hop;
            res.entry_link = cur_link;
        end
        else
        begin
            res.entry_hop  = '0;
            res.entry_link = '0;
        end

        wr.en   = commit && take;
        wr.node = row.dest_node;
        wr.hop  = cand;
        wr.link = row.via_link;

        changed_next = row.last_row ? 1'b0 : (changed_so_far || take);
    end

endmodule

// File: sv/distance_vector_table_update_unit.sv
// top level of the distance-vector table update block
// depends on dvt_pkg, dvt_route_table, dvt_update_logic and assert_macros.svh
`timescale 1ns / 1ps
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    s_tdata, s_tlast  (received table rows)
// m_*       out        m_tvalid / m_tready    m_tdata, m_tuser, m_tlast  (resulting entries)
// cfg_*     in         cfg_valid / cfg_ready  cfg_data  (own node id)
//
// one row per cycle sustained unless m_tready stalls; a result is offered from the output
// register after the row stage, which the registered read of the hop/link memory needs: a row
// reads at its accept edge and decides in the row stage, the row ahead's write is forwarded
// reset clears all valid flags at once, so rows are taken right after reset
// a stalled result holds in the output register while one more row waits in the row stage

module distance_vector_table_update_unit #(
    parameter int NODE_COUNT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // dest_node [5:0], recv_hop [13:6], via_link [19:14], zero [23:20]
    input  logic [dvt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_updated [0], entry_hop [8:1], entry_link [14:9], table_changed [15]
    output logic [dvt_pkg::M_TDATA_W-1:0]     m_tdata,
    // row_skipped [0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  dvt_pkg::node_t                    cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);
    import dvt_pkg::*;

    `include "assert_macros.svh"

    // row stage
    logic      s1_valid_reg;
    logic      s1_valid_next;
    row_t      s1_row_reg;
    row_t      s_row;
    // write of the row ahead, captured at the accept edge of the next row
    route_wr_t fwd_reg;
    // output register
    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   out_res_reg;
    // settings and running flag
    node_t     own_node_reg;
    logic      changed_reg;
    logic      changed_next;

    logic      s_accept;
    logic      advance;
    logic      cur_valid;
    hop_t      mem_hop;
    link_t     mem_link;
    result_t   res;
    route_wr_t wr;

    assign cfg_ready = 1'b1;

    // unpack the incoming row
    assign s_row.dest_node = s_tdata[NODE_W-1:0];
    assign s_row.recv_hop  = s_tdata[NODE_W+HOP_W-1:NODE_W];
    assign s_row.via_link  = s_tdata[NODE_W+HOP_W+LINK_W-1:NODE_W+HOP_W];
    assign s_row.last_row  = s_tlast;

    // row stage moves on when the output register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign s1_valid_next  = s_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    dvt_route_table #(
        .NODE_COUNT (NODE_COUNT)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_en      (s_accept),
        .rd_node    (s_row.dest_node),
        .rd_hop     (mem_hop),
        .rd_link    (mem_link),
        .look_node  (s1_row_reg.dest_node),
        .look_valid (cur_valid)
    );

    dvt_update_logic #(
        .NODE_COUNT (NODE_COUNT)
    ) u_update (
        .row            (s1_row_reg),
        .own_node       (own_node_reg),
        .cur_valid      (cur_valid),
        .mem_hop        (mem_hop),
        .mem_link       (mem_link),
        .fwd            (fwd_reg),
        .changed_so_far (changed_reg),
        .commit         (advance),
        .res            (res),
        .wr             (wr),
        .changed_next   (changed_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            own_node_reg  <= '0;
            changed_reg   <= 1'b0;
            fwd_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                own_node_reg <= cfg_data;
            end
            if (advance)
            begin
                changed_reg <= changed_next;
            end
            // the new row read the memory before this write landed
            if (s_accept)
            begin
                fwd_reg <= wr;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_row_reg <= s_row;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.table_changed, out_res_reg.entry_link,
                       out_res_reg.entry_hop, out_res_reg.entry_updated};
    assign m_tuser  = out_res_reg.row_skipped;
    assign m_tlast  = out_res_reg.end_of_table;

    // a skipped row never touches the table, so it reports no update and a zero entry
    `DVT_ASSERT_NOW(a_skip_no_update, clk, rst_n, m_tvalid && m_tuser, !m_tdata[0] && (m_tdata[14:1] == '0), "skipped row reported an entry")

    // changed flag only rides on the last row
    `DVT_ASSERT_NOW(a_changed_on_last, clk, rst_n, m_tvalid && !m_tlast, !m_tdata[15], "table_changed set off the last row")

    // table writes happen only as the row stage hands its result on
    `DVT_ASSERT_NOW(a_write_on_advance, clk, rst_n, wr.en, s1_valid_reg && advance, "table written without a row moving on")

    // a held row stays in the row stage
    `DVT_ASSERT_NEXT(a_row_held, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg, "row lost while stalled")

endmodule

// File: tb/testbench.sv
// self-checking bench for distance_vector_table_update_unit
// depends on dvt_pkg and the rtl of the block; predicts every result entry from the rows it sends
`timescale 1ns / 1ps

module testbench;

    import dvt_pkg::*;

    localparam int          CLK_HALF    = 2;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          EXP_DEPTH   = 16;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    node_t                cfg_data  = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    distance_vector_table_update_unit #(
        .NODE_COUNT(NODE_SPAN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_data(cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    // shadow copy of the route table
    logic      route_ok  [NODE_SPAN];
    hop_t      route_hop [NODE_SPAN];
    link_t     route_via [NODE_SPAN];
    logic      table_dirty = 1'b0;
    node_t     own_id      = '0;

    // expected entries in row order, ring with running counts
    result_t   exp_ring [EXP_DEPTH];
    int        exp_wr_cnt   = 0;
    int        exp_rd_cnt   = 0;
    int        rows_sent    = 0;
    int        entries_seen = 0;
    int        mismatches   = 0;

    // traffic shaping knobs, changed per test
    bit        tx_gaps_on   = 1'b0;
    bit        rx_stalls_on = 1'b0;
    int        hold_request = 0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NODE_SPAN; i++)
            route_ok[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout with %0d entries outstanding", $time,
                 exp_wr_cnt - exp_rd_cnt);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 2);
    endfunction

    // apply one row to the shadow table, return the entry the block should report
    function automatic result_t apply_row(row_t r);
        result_t res;
        hop_t    cand;
        res = '0;
        if (r.dest_node == own_id)
        begin
            res.row_skipped = 1'b1;
        end
        else
        begin
            // received count plus one, held at the top of the range
            cand = (r.recv_hop == HOP_MAX) ? HOP_MAX : r.recv_hop + 8'd1;
            if (!route_ok[r.dest_node] || cand < route_hop[r.dest_node])
            begin
                route_ok[r.dest_node]  = 1'b1;
                route_hop[r.dest_node] = cand;
                route_via[r.dest_node] = r.via_link;
                res.entry_updated      = 1'b1;
                table_dirty            = 1'b1;
            end
            res.entry_hop  = route_hop[r.dest_node];
            res.entry_link = route_via[r.dest_node];
        end
        // changed flag is reported on the last row and then starts afresh
        if (r.last_row)
        begin
            res.table_changed = table_dirty;
            table_dirty       = 1'b0;
        end
        res.end_of_table = r.last_row;
        return res;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    // result checker first, then the predictor for the row taken at the same edge
    always @(posedge clk)
    begin
        result_t exp_entry;
        row_t    taken;
        if (rst_n && m_tvalid && m_tready)
        begin
            entries_seen++;
            if (exp_wr_cnt == exp_rd_cnt)
            begin
                mismatches++;
                $display("%0t ns: unexpected entry, expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                exp_entry = exp_ring[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                check_field("entry_updated", exp_entry.entry_updated, m_tdata[0]);
                check_field("entry_hop", exp_entry.entry_hop, m_tdata[8:1]);
                check_field("entry_link", exp_entry.entry_link, m_tdata[14:9]);
                check_field("table_changed", exp_entry.table_changed, m_tdata[15]);
                check_field("row_skipped", exp_entry.row_skipped, m_tuser);
                check_field("end_of_table", exp_entry.end_of_table, m_tlast);
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            taken.dest_node = s_tdata[5:0];
            taken.recv_hop  = s_tdata[13:6];
            taken.via_link  = s_tdata[19:14];
            taken.last_row  = s_tlast;
            exp_ring[exp_wr_cnt % EXP_DEPTH] = apply_row(taken);
            exp_wr_cnt++;
        end
        if (rst_n && cfg_valid && cfg_ready)
            own_id = cfg_data;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int run_left;
        int hold_left;
        run_left  = 0;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
                run_left = 0;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                run_left = pick_gap() - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                run_left = $urandom_range(0, 6);
            end
        end
    end

    // offer one row and hold it until taken; s_tvalid stays high when no gap follows
    task automatic send_row(row_t r);
        int gap;
        s_tdata  <= {4'b0, r.via_link, r.recv_hop, r.dest_node};
        s_tlast  <= r.last_row;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        rows_sent++;
        if (tx_gaps_on && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(int dest, int hop, int link, bit last);
        row_t r;
        r.dest_node = node_t'(dest);
        r.recv_hop  = hop_t'(hop);
        r.via_link  = link_t'(link);
        r.last_row  = last;
        send_row(r);
    endtask

    // let every row drain so the block is idle
    task automatic drain_rows();
        s_tvalid <= 1'b0;
        wait (entries_seen == rows_sent);
    endtask

    // own node id only changes while no row is in flight
    task automatic write_own_node(node_t id);
        drain_rows();
        cfg_data  <= id;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // install, keep, improve, skip and saturation, with the changed flag on last rows
    task automatic test_directed_rows();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        // own node still at its reset value of zero
        send_fields(0, 5, 3, 1'b0);      // own node, skipped
        send_fields(1, 0, 0, 1'b0);      // absent entry installed at one hop
        send_fields(1, 0, 63, 1'b0);     // equal route kept
        send_fields(1, 255, 63, 1'b1);   // worse route kept, table changed
        send_fields(2, 255, 63, 1'b0);   // saturated count installs an absent entry
        send_fields(2, 254, 1, 1'b0);    // same saturated count, kept
        send_fields(2, 253, 42, 1'b0);   // one better, replaced
        send_fields(0, 0, 0, 1'b1);      // skipped last row still reports the change
        send_fields(1, 7, 5, 1'b1);      // lone row, no change
        send_fields(63, 128, 21, 1'b1);  // lone row that installs
        write_own_node(6'd63);
        send_fields(63, 0, 0, 1'b0);     // now skipped
        send_fields(0, 254, 63, 1'b0);   // first route to node zero
        send_fields(0, 0, 0, 1'b1);      // improved to one hop
        send_fields(63, 255, 63, 1'b1);  // skipped last row, nothing changed
        write_own_node(6'd42);
        send_fields(42, 255, 63, 1'b0);
        send_fields(41, 255, 0, 1'b0);
        send_fields(41, 100, 32, 1'b1);
    endtask

    // random tables ending with a last row; hop counts fall from phase to phase
    // so that entries keep improving
    task automatic test_random_tables(node_t own, int rows_wanted, int hop_lo, int hop_hi,
                                      bit tx_gaps, bit rx_stalls);
        int   sent;
        int   span;
        int   pick;
        row_t r;
        write_own_node(own);
        tx_gaps_on   = tx_gaps;
        rx_stalls_on = rx_stalls;
        sent = 0;
        while (sent < rows_wanted)
        begin
            span = $urandom_range(1, 10);
            for (int i = 0; i < span; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    r.dest_node = own;
                else if (pick < 6)
                    r.dest_node = node_t'($urandom_range(0, 15));
                else
                    r.dest_node = node_t'($urandom_range(0, 63));
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    r.recv_hop = HOP_MAX;
                else if (pick == 1)
                    r.recv_hop = 8'd0;
                else
                    r.recv_hop = hop_t'($urandom_range(hop_lo, hop_hi));
                r.via_link = link_t'($urandom_range(0, 63));
                r.last_row = (i == span - 1);
                send_row(r);
                sent++;
            end
        end
    endtask

    // receiver holds off while rows keep coming, the block fills and stops taking rows
    task automatic test_output_backpressure();
        row_t r;
        drain_rows();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_request = 160;
        for (int i = 0; i < 40; i++)
        begin
            r.dest_node = node_t'($urandom_range(0, 63));
            r.recv_hop  = hop_t'($urandom_range(0, 255));
            r.via_link  = link_t'($urandom_range(0, 63));
            r.last_row  = ($urandom_range(0, 4) == 0);
            send_row(r);
        end
    endtask

    initial
    begin
        wait (rst_n);
        test_directed_rows();
        test_random_tables(6'd63, 130, 180, 255, 1'b1, 1'b1);
        test_random_tables(6'd0, 130, 100, 220, 1'b0, 1'b0);
        test_random_tables(node_t'($urandom_range(0, 63)), 130, 40, 140, 1'b1, 1'b1);
        test_random_tables(node_t'($urandom_range(0, 63)), 130, 10, 60, 1'b1, 1'b0);
        test_output_backpressure();
        test_random_tables(node_t'($urandom_range(0, 63)), 110, 0, 20, 1'b1, 1'b1);
        drain_rows();
        // allow a stray entry to show up past the pipeline depth
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
